// File: rtl/srfp_pkg.sv
// Shared types, codes and tables for the stat record field parser.
package srfp_pkg;

    localparam logic [1:0] KIND_FIELD   = 2'd0;
    localparam logic [1:0] KIND_STRBYTE = 2'd1;
    localparam logic [1:0] KIND_STREND  = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_SHORT  = 3'd1;
    localparam logic [2:0] ST_PREFIX = 3'd2;
    localparam logic [2:0] ST_BODY   = 3'd3;
    localparam logic [2:0] ST_SIZE   = 3'd4;
    localparam logic [2:0] ST_TRAIL  = 3'd5;

    localparam logic [3:0] PHASE_STRINGS = 4'd10;
    localparam logic [3:0] PHASE_WAIT    = 4'd11;

    localparam logic [2:0]  NUM_STRINGS = 3'd4;
    localparam logic [16:0] MIN_RECORD  = 17'd49;
    localparam logic [16:0] OFFSET_MAX  = 17'h1FFFF;

    localparam logic CFG_STRICT  = 1'b0;
    localparam logic CFG_DELIVER = 1'b1;

    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  index;
        logic [63:0] value;
        logic [2:0]  status;
        logic [16:0] consumed;
        logic        last;
    } srfp_result_t;

    typedef struct packed {
        logic [1:0]              count;
        srfp_result_t [1:0]      item;
    } srfp_push_t;

    typedef struct packed {
        logic [16:0] offset;
        logic [63:0] acc;
        logic [3:0]  pos;
        logic [3:0]  fnum;
        logic [2:0]  snum;
        logic [15:0] srem;
        logic [15:0] dsize;
        logic        finished;
    } srfp_state_t;

    function automatic logic [3:0] fixed_len(input logic [3:0] fnum);
        logic [3:0] len;
        case (fnum)
            4'd0, 4'd1:                   len = 4'd2;
            4'd3:                         len = 4'd1;
            4'd5, 4'd9:                   len = 4'd8;
            default:                      len = 4'd4;
        endcase
        return len;
    endfunction

    function automatic srfp_result_t make_result(input logic [1:0] kind,
                                                 input logic [3:0] index,
                                                 input logic [63:0] value,
                                                 input logic [2:0] status,
                                                 input logic [16:0] consumed);
        srfp_result_t r;
        r.kind     = kind;
        r.index    = index;
        r.value    = value;
        r.status   = status;
        r.consumed = consumed;
        r.last     = 1'b0;
        return r;
    endfunction

endpackage

// File: rtl/srfp_parse.sv
// Parse state registers and per-byte field, string and record-end logic.
module srfp_parse (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fire,
    input  logic [7:0]               data_byte,
    input  logic                     last_byte,
    input  logic                     strict_check,
    input  logic                     deliver_strings,
    output srfp_pkg::srfp_push_t     push
);

    srfp_pkg::srfp_state_t state_reg;
    srfp_pkg::srfp_state_t state_next;

    srfp_pkg::srfp_result_t ra;
    srfp_pkg::srfp_result_t rd;
    logic                   va;
    logic                   vd;
    logic                   completed;
    logic                   ended;
    logic                   clear_all;
    logic [16:0]            off_n;
    logic [63:0]            acc_n;
    logic [3:0]             pos_inc;
    logic [15:0]            len;
    logic [15:0]            srem_n;
    logic [2:0]             snum_inc;
    logic                   mismatch;
    logic [2:0]             st;

    always_comb
    begin
        state_next = state_reg;
        ra         = '0;
        rd         = '0;
        va         = 1'b0;
        vd         = 1'b0;
        completed  = 1'b0;
        ended      = 1'b0;
        clear_all  = 1'b0;
        off_n      = state_reg.offset;
        acc_n      = state_reg.acc | ({56'd0, data_byte} << {state_reg.pos[2:0], 3'b000});
        pos_inc    = state_reg.pos + 4'd1;
        len        = {data_byte, state_reg.acc[7:0]};
        srem_n     = state_reg.srem - 16'd1;
        snum_inc   = state_reg.snum + 3'd1;
        mismatch   = 1'b0;
        st         = srfp_pkg::ST_OK;

        if (state_reg.finished)
        begin
            clear_all = last_byte;
        end
        else
        begin
            if (state_reg.offset != srfp_pkg::OFFSET_MAX)
            begin
                off_n = state_reg.offset + 17'd1;
            end
            state_next.offset = off_n;

            if (state_reg.fnum < srfp_pkg::PHASE_STRINGS)
            begin
                if (pos_inc >= srfp_pkg::fixed_len(state_reg.fnum))
                begin
                    ra = srfp_pkg::make_result(srfp_pkg::KIND_FIELD, state_reg.fnum, acc_n,
                                               srfp_pkg::ST_OK, 17'd0);
                    va = 1'b1;
                    if (state_reg.fnum == 4'd0)
                    begin
                        state_next.dsize = acc_n[15:0];
                    end
                    state_next.fnum = state_reg.fnum + 4'd1;
                    state_next.acc  = '0;
                    state_next.pos  = '0;
                end
                else
                begin
                    state_next.acc = acc_n;
                    state_next.pos = pos_inc;
                end
            end
            else if (state_reg.fnum == srfp_pkg::PHASE_STRINGS)
            begin
                if (state_reg.pos == 4'd0)
                begin
                    state_next.acc = {56'd0, data_byte};
                    state_next.pos = 4'd1;
                end
                else if (state_reg.pos == 4'd1)
                begin
                    state_next.acc = '0;
                    if (len == 16'd0)
                    begin
                        ra = srfp_pkg::make_result(srfp_pkg::KIND_STREND, {1'b0, state_reg.snum},
                                                   64'd0, srfp_pkg::ST_OK, 17'd0);
                        va    = 1'b1;
                        ended = 1'b1;
                    end
                    else
                    begin
                        state_next.srem = len;
                        state_next.pos  = 4'd2;
                    end
                end
                else
                begin
                    state_next.srem = srem_n;
                    if (srem_n == 16'd0)
                    begin
                        ra = srfp_pkg::make_result(srfp_pkg::KIND_STREND, {1'b0, state_reg.snum},
                                                   deliver_strings ? {56'd0, data_byte} : 64'd0,
                                                   srfp_pkg::ST_OK, 17'd0);
                        va    = 1'b1;
                        ended = 1'b1;
                    end
                    else if (deliver_strings)
                    begin
                        ra = srfp_pkg::make_result(srfp_pkg::KIND_STRBYTE, {1'b0, state_reg.snum},
                                                   {56'd0, data_byte}, srfp_pkg::ST_OK, 17'd0);
                        va = 1'b1;
                    end
                end
                if (ended)
                begin
                    state_next.snum = snum_inc;
                    state_next.pos  = '0;
                    if (snum_inc >= srfp_pkg::NUM_STRINGS)
                    begin
                        completed       = 1'b1;
                        state_next.fnum = srfp_pkg::PHASE_WAIT;
                    end
                end
            end

            mismatch = off_n != ({1'b0, state_next.dsize} + 17'd2);

            if (completed)
            begin
                if (last_byte)
                begin
                    st = (strict_check && mismatch) ? srfp_pkg::ST_SIZE : srfp_pkg::ST_OK;
                    rd = srfp_pkg::make_result(srfp_pkg::KIND_DONE, 4'd0, 64'd0, st,
                                               (st == srfp_pkg::ST_OK) ? off_n : 17'd0);
                    vd        = 1'b1;
                    clear_all = 1'b1;
                end
                else if (!strict_check)
                begin
                    rd = srfp_pkg::make_result(srfp_pkg::KIND_DONE, 4'd0, 64'd0,
                                               srfp_pkg::ST_OK, off_n);
                    vd                  = 1'b1;
                    state_next.finished = 1'b1;
                end
            end
            else if (last_byte)
            begin
                if (state_next.fnum >= srfp_pkg::PHASE_WAIT)
                begin
                    st = mismatch ? srfp_pkg::ST_SIZE : srfp_pkg::ST_TRAIL;
                end
                else if (off_n < srfp_pkg::MIN_RECORD ||
                         state_next.fnum < srfp_pkg::PHASE_STRINGS)
                begin
                    st = srfp_pkg::ST_SHORT;
                end
                else if (state_next.pos < 4'd2)
                begin
                    st = srfp_pkg::ST_PREFIX;
                end
                else
                begin
                    st = srfp_pkg::ST_BODY;
                end
                rd = srfp_pkg::make_result(srfp_pkg::KIND_DONE, 4'd0, 64'd0, st, 17'd0);
                vd        = 1'b1;
                clear_all = 1'b1;
            end
        end

        if (clear_all)
        begin
            state_next = '0;
        end
    end

    always_comb
    begin
        push.item = '0;
        if (va)
        begin
            push.item[0] = ra;
            push.item[1] = rd;
            push.count   = vd ? 2'd2 : 2'd1;
        end
        else
        begin
            push.item[0] = rd;
            push.count   = vd ? 2'd1 : 2'd0;
        end
        if (push.count == 2'd2)
        begin
            push.item[1].last = 1'b1;
        end
        else
        begin
            push.item[0].last = 1'b1;
        end
        if (!fire)
        begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/srfp_outq.sv
// Result queue: takes up to two results per cycle, presents one per transfer.
module srfp_outq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  srfp_pkg::srfp_push_t       push,
    output logic                       space,
    output logic                       out_valid,
    input  logic                       out_ready,
    output srfp_pkg::srfp_result_t     head
);

    srfp_pkg::srfp_result_t [srfp_pkg::Q_DEPTH-1:0] q_reg;
    srfp_pkg::srfp_result_t [srfp_pkg::Q_DEPTH-1:0] q_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic [2:0] base;
    logic       pop;

    assign out_valid = cnt_reg != 3'd0;
    assign space     = cnt_reg <= 3'd2;
    assign head      = q_reg[0];
    assign pop       = out_valid && out_ready;
    assign base      = cnt_reg - {2'd0, pop};
    assign cnt_next  = base + {1'b0, push.count};

    always_comb
    begin
        for (int i = 0; i < srfp_pkg::Q_DEPTH; i++)
        begin
            if (pop && i < srfp_pkg::Q_DEPTH - 1)
            begin
                q_next[i] = q_reg[i+1];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
            if (push.count != 2'd0 && base == 3'(i))
            begin
                q_next[i] = push.item[0];
            end
            if (push.count == 2'd2 && base + 3'd1 == 3'(i))
            begin
                q_next[i] = push.item[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: rtl/stat_record_field_parser_core.sv
// Top level of the stat record field parser: config registers, parser and result queue.
//
// Takes one stat record byte per transfer, with last_byte on the final byte of
// the buffer, and returns fixed fields, string bytes (when delivery is enabled),
// string ends and one record-done result carrying status and bytes consumed. A
// byte is parsed in the cycle it is accepted and its results are registered in
// the result queue, whose head drives the output. One byte can be accepted every
// cycle while the four-entry result queue has room for two results; the output
// side delivers one result per cycle while out_ready is high, so a byte that
// yields two results (a field, string byte or string end plus record done)
// presents them in turn. Configuration writes take effect on the next accepted byte.
module stat_record_field_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [3:0]  field_index,
    output logic [63:0] field_value,
    output logic [2:0]  status,
    output logic [16:0] bytes_consumed,
    output logic        last_of_run
);

    logic                   strict_reg;
    logic                   deliver_reg;
    logic                   fire;
    srfp_pkg::srfp_push_t   push;
    srfp_pkg::srfp_result_t head;

    assign fire = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_reg  <= 1'b0;
            deliver_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                srfp_pkg::CFG_STRICT:  strict_reg  <= cfg_data;
                srfp_pkg::CFG_DELIVER: deliver_reg <= cfg_data;
                default:               strict_reg  <= strict_reg;
            endcase
        end
    end

    srfp_parse u_parse (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .strict_check    (strict_reg),
        .deliver_strings (deliver_reg),
        .push            (push)
    );

    srfp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign result_kind    = head.kind;
    assign field_index    = head.index;
    assign field_value    = head.value;
    assign status         = head.status;
    assign bytes_consumed = head.consumed;
    assign last_of_run    = head.last;

endmodule

// File: rtl/srfp_checker.sv
// Port-level assertions for the stat record field parser, bound to the top level.
module srfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  result_kind,
    input logic [63:0] field_value,
    input logic [2:0]  status,
    input logic [16:0] bytes_consumed,
    input logic        last_of_run
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(field_value) && $stable(result_kind))
        else $error("result changed while stalled");

    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == srfp_pkg::KIND_DONE |-> last_of_run)
        else $error("record done not last of run");

    a_status_done_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != srfp_pkg::KIND_DONE |->
            status == srfp_pkg::ST_OK && bytes_consumed == 17'd0)
        else $error("status or count on non-done result");

    a_fail_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != srfp_pkg::ST_OK |-> bytes_consumed == 17'd0 &&
            field_value == 64'd0)
        else $error("failed record reports bytes");

endmodule

bind stat_record_field_parser_core srfp_checker u_srfp_checker (.*);

// File: verif/stat_record_checker.sv
`timescale 1ns / 100ps
// Checker for the stat record field parser: predicts the results of each byte and compares them.
module stat_record_checker
    import srfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic        cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  result_kind,
    input  logic [3:0]  field_index,
    input  logic [63:0] field_value,
    input  logic [2:0]  status,
    input  logic [16:0] bytes_consumed,
    input  logic        last_of_run,
    output int          mismatches,
    output int          outstanding
);

    srfp_result_t expected_results [$];
    int           miss_count;
    logic         strict_mode;
    logic         deliver_mode;
    logic [16:0]  taken;
    logic [63:0]  accum;
    logic [3:0]   byte_pos;
    logic [3:0]   phase;
    logic [2:0]   str_num;
    logic [15:0]  str_left;
    logic [15:0]  size_field;
    logic         parked;

    function automatic logic [3:0] field_width(input logic [3:0] n);
        case (n)
            4'd3:       return 4'd1;
            4'd0, 4'd1: return 4'd2;
            4'd5, 4'd9: return 4'd8;
            default:    return 4'd4;
        endcase
    endfunction

    function automatic srfp_result_t entry(input logic [1:0] kind, input logic [3:0] idx,
                                           input logic [63:0] value, input logic [2:0] st,
                                           input logic [16:0] count);
        srfp_result_t r;
        r.kind     = kind;
        r.index    = idx;
        r.value    = value;
        r.status   = st;
        r.consumed = count;
        r.last     = 1'b0;
        return r;
    endfunction

    task automatic restart_record();
        taken      = '0;
        accum      = '0;
        byte_pos   = '0;
        phase      = '0;
        str_num    = '0;
        str_left   = '0;
        size_field = '0;
        parked     = 1'b0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic mark);
        srfp_result_t batch [$];
        logic         finished_here;
        logic         ended;
        logic [15:0]  len;
        logic [2:0]   st;
        finished_here = 1'b0;
        ended         = 1'b0;
        if (parked)
        begin
            if (mark)
                restart_record();
            return;
        end
        if (taken != OFFSET_MAX)
            taken = taken + 17'd1;

        if (phase < PHASE_STRINGS)
        begin
            accum    = accum | (64'(b) << (8 * byte_pos[2:0]));
            byte_pos = byte_pos + 4'd1;
            if (byte_pos >= field_width(phase))
            begin
                batch.push_back(entry(KIND_FIELD, phase, accum, ST_OK, '0));
                if (phase == 4'd0)
                    size_field = accum[15:0];
                phase    = phase + 4'd1;
                accum    = '0;
                byte_pos = '0;
            end
        end
        else if (phase == PHASE_STRINGS)
        begin
            if (byte_pos == 4'd0)
            begin
                accum    = 64'(b);
                byte_pos = 4'd1;
            end
            else if (byte_pos == 4'd1)
            begin
                len   = {b, accum[7:0]};
                accum = '0;
                if (len == 16'd0)
                begin
                    batch.push_back(entry(KIND_STREND, {1'b0, str_num}, '0, ST_OK, '0));
                    ended = 1'b1;
                end
                else
                begin
                    str_left = len;
                    byte_pos = 4'd2;
                end
            end
            else
            begin
                str_left = str_left - 16'd1;
                if (str_left == 16'd0)
                begin
                    batch.push_back(entry(KIND_STREND, {1'b0, str_num},
                                          deliver_mode ? 64'(b) : 64'd0, ST_OK, '0));
                    ended = 1'b1;
                end
                else if (deliver_mode)
                    batch.push_back(entry(KIND_STRBYTE, {1'b0, str_num}, 64'(b), ST_OK, '0));
            end
            if (ended)
            begin
                str_num  = str_num + 3'd1;
                byte_pos = '0;
                if (str_num >= NUM_STRINGS)
                begin
                    finished_here = 1'b1;
                    phase         = PHASE_WAIT;
                end
            end
        end

        if (finished_here)
        begin
            if (mark)
            begin
                st = (strict_mode && taken != 17'(size_field) + 17'd2) ? ST_SIZE : ST_OK;
                batch.push_back(entry(KIND_DONE, '0, '0, st, (st == ST_OK) ? taken : '0));
                restart_record();
            end
            else if (!strict_mode)
            begin
                batch.push_back(entry(KIND_DONE, '0, '0, ST_OK, taken));
                parked = 1'b1;
            end
        end
        else if (mark)
        begin
            if (phase >= PHASE_WAIT)
                st = (taken != 17'(size_field) + 17'd2) ? ST_SIZE : ST_TRAIL;
            else if (taken < MIN_RECORD || phase < PHASE_STRINGS)
                st = ST_SHORT;
            else if (byte_pos < 4'd2)
                st = ST_PREFIX;
            else
                st = ST_BODY;
            batch.push_back(entry(KIND_DONE, '0, '0, st, '0));
            restart_record();
        end

        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            expected_results.push_back(batch[i]);
    endtask

    task automatic report(input string why, input srfp_result_t want, input srfp_result_t got);
        miss_count++;
        if (miss_count <= 10)
            $display({"%s at %0t: expected kind %0d index %0d value %h status %0d ",
                      "consumed %0d last %0d, got kind %0d index %0d value %h status %0d ",
                      "consumed %0d last %0d"},
                     why, $realtime,
                     want.kind, want.index, want.value, want.status, want.consumed, want.last,
                     got.kind, got.index, got.value, got.status, got.consumed, got.last);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        srfp_result_t got;
        srfp_result_t want;
        if (!rst_n)
        begin
            strict_mode  = 1'b0;
            deliver_mode = 1'b1;
            restart_record();
            expected_results.delete();
            miss_count   = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_STRICT)
                    strict_mode = cfg_data;
                else
                    deliver_mode = cfg_data;
            end
            if (in_valid && in_ready)
                parse_byte(data_byte, last_byte);
            if (out_valid && out_ready)
            begin
                got.kind     = result_kind;
                got.index    = field_index;
                got.value    = field_value;
                got.status   = status;
                got.consumed = bytes_consumed;
                got.last     = last_of_run;
                if (expected_results.size() == 0)
                begin
                    want = '0;
                    report("Unexpected result", want, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                        report("Mismatch", want, got);
                end
            end
            mismatches  <= miss_count;
            outstanding <= expected_results.size();
        end
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Testbench top for the stat record field parser: clock, reset, record stimulus and verdict.
module tb;
    import srfp_pkg::*;

    localparam int FILL_RANDOM  = 0;
    localparam int FILL_ZERO    = 1;
    localparam int FILL_ONES    = 2;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic        cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  result_kind;
    logic [3:0]  field_index;
    logic [63:0] field_value;
    logic [2:0]  status;
    logic [16:0] bytes_consumed;
    logic        last_of_run;
    int          mismatches;
    int          outstanding;

    logic [7:0]  rec [$];
    bit          no_idle = 1'b0;
    int          holds_asked = 0;
    int          holds_served = 0;
    int          bytes_sent = 0;
    int          stall_cycles = 0;

    stat_record_field_parser_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .field_index    (field_index),
        .field_value    (field_value),
        .status         (status),
        .bytes_consumed (bytes_consumed),
        .last_of_run    (last_of_run)
    );

    stat_record_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .field_index    (field_index),
        .field_value    (field_value),
        .status         (status),
        .bytes_consumed (bytes_consumed),
        .last_of_run    (last_of_run),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // result receiver: random stalls, plus long hold-offs on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_asked)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_served++;
            end
            else
                out_ready <= no_idle || ($urandom_range(99) >= 37);
        end
    end

    function automatic logic [63:0] fill_value(input int fill);
        if (fill == FILL_ZERO)
            return '0;
        if (fill == FILL_ONES)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic int string_length();
        if ($urandom_range(9) == 0)
            return $urandom_range(20, 80);
        return $urandom_range(0, 5);
    endfunction

    task automatic put_le(input logic [63:0] value, input int n);
        for (int i = 0; i < n; i++)
            rec.push_back(value[8*i +: 8]);
    endtask

    task automatic add_string(input int len, input int fill);
        put_le(64'(len), 2);
        for (int i = 0; i < len; i++)
            rec.push_back(8'(fill_value(fill)));
    endtask

    // adj < 0 gives a size field that never matches the record
    task automatic make_record(input int l0, input int l1, input int l2, input int l3,
                               input int fill, input int adj);
        logic [15:0] sz;
        rec.delete();
        put_le(64'd0, 2);
        for (int f = 1; f < 10; f++)
            put_le(fill_value(fill), (f == 3) ? 1 : (f == 5 || f == 9) ? 8 : (f == 1) ? 2 : 4);
        add_string(l0, fill);
        add_string(l1, fill);
        add_string(l2, fill);
        add_string(l3, fill);
        if (adj < 0)
        begin
            sz = 16'($urandom);
            if (sz == 16'(rec.size() - 2))
                sz = ~sz;
        end
        else
            sz = 16'(rec.size() - 2 + adj);
        rec[0] = sz[7:0];
        rec[1] = sz[15:8];
    endtask

    task automatic send_byte(input logic [7:0] value, input logic mark);
        while (!no_idle && $urandom_range(99) < 37)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        last_byte <= mark;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // cut > 0 ends the buffer early; tail appends bytes after the record
    task automatic send_record(input int cut, input int tail);
        int n;
        n = (cut > 0) ? cut : rec.size();
        for (int i = 0; i < n; i++)
            send_byte(rec[i], (i == n - 1) && (tail == 0));
        for (int i = 0; i < tail; i++)
            send_byte(8'($urandom), i == tail - 1);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_mode(input logic strict, input logic deliver);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= CFG_STRICT;
        cfg_data  <= strict;
        @(posedge clk);
        cfg_index <= CFG_DELIVER;
        cfg_data  <= deliver;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic random_record();
        int  pick;
        int  a;
        int  b;
        int  tail;
        int  adj;
        int  cut;
        bit  big;
        pick = $urandom_range(99);
        tail = 0;
        cut  = 0;
        if (pick < 12)
        begin
            rec.delete();
            repeat ($urandom_range(1, 70))
                rec.push_back(8'($urandom));
        end
        else
        begin
            a   = string_length();
            b   = string_length();
            big = (pick < 30) && ($urandom_range(1) == 1);
            if (big)
                b = $urandom_range(256, 65535);
            adj = ($urandom_range(4) == 0) ? -1 : 0;
            if (pick >= 30 && $urandom_range(4) == 0)
            begin
                tail = $urandom_range(1, 3);
                if ($urandom_range(1) == 1)
                    adj = tail;
            end
            make_record(a, b, string_length(), string_length(), FILL_RANDOM, adj);
            if (pick < 30)
                cut = big ? 41 + 2 + a + 2 + $urandom_range(1, 20)
                          : $urandom_range(1, rec.size() - 1);
        end
        send_record(cut, tail);
    endtask

    task automatic run_random(input int quota);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < quota)
            random_record();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_STRICT;
        cfg_data  = 1'b0;
        in_valid  = 1'b0;
        data_byte = 8'd0;
        last_byte = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        set_mode(1'b0, 1'b1);
        make_record(0, 0, 0, 0, FILL_ZERO, 0);
        send_record(0, 0);
        make_record(1, 2, 3, 1, FILL_ONES, 0);
        send_record(0, 0);
        make_record(3, 3, 3, 3, FILL_RANDOM, 0);
        send_record(1, 0);
        send_record(41, 0);
        send_record(57, 0);
        send_record(59, 0);
        make_record(2, 0, 4, 1, FILL_RANDOM, -1);
        send_record(0, 0);
        make_record(1, 1, 1, 1, FILL_RANDOM, 0);
        send_record(0, 3);

        set_mode(1'b1, 1'b1);
        make_record(2, 2, 2, 2, FILL_RANDOM, 0);
        send_record(0, 0);
        make_record(2, 2, 2, 2, FILL_RANDOM, -1);
        send_record(0, 0);
        make_record(0, 1, 0, 1, FILL_RANDOM, 2);
        send_record(0, 2);
        make_record(0, 1, 0, 1, FILL_RANDOM, 0);
        send_record(0, 2);
        make_record(3, 3, 3, 3, FILL_RANDOM, 0);
        send_record(59, 0);

        set_mode(1'b0, 1'b0);
        make_record(4, 0, 2, 1, FILL_RANDOM, 0);
        send_record(0, 0);
        make_record(1, 1, 1, 1, FILL_RANDOM, 0);
        send_record(0, 2);

        set_mode(1'b1, 1'b0);
        make_record(2, 3, 0, 1, FILL_RANDOM, 0);
        send_record(0, 0);

        set_mode(1'b0, 1'b1);
        holds_asked++;
        run_random(100);
        set_mode(1'b1, 1'b1);
        run_random(100);
        set_mode(1'b0, 1'b0);
        no_idle = 1'b1;
        run_random(100);
        no_idle = 1'b0;
        set_mode(1'b1, 1'b0);
        holds_asked++;
        run_random(100);

        set_mode(1'b0, 1'b1);
        run_random(40);

        settle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
rtl/srfp_pkg.sv
rtl/srfp_parse.sv
rtl/srfp_outq.sv
rtl/stat_record_field_parser_core.sv
rtl/srfp_checker.sv
verif/stat_record_checker.sv
verif/tb.sv
